/* src/stwt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stwt_pkg: shared types and constants for the session table
// Entry layout, cell control word, operation codes and register reset values.
// ----------------------------------------------------------------------------
package stwt_pkg;

	// Width of counts and positions; also the width of the count outputs.
	localparam int unsigned CNT_W = 7;
	localparam int unsigned KEY_UPPER_W = 16;
	localparam int unsigned KEY_LOWER_W = 64;
	localparam int unsigned NOW_W = 32;
	localparam int unsigned EXPIRY_W = NOW_W + 1;
	localparam int unsigned TIMEOUT_W = 16;
	localparam int unsigned FUNC_W = 2;

	// Lifetime in seconds after reset.
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1800;

	// Operation codes carried on the input side band.
	localparam logic [FUNC_W-1:0] FUNC_CREATE = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_VALIDATE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

	// One table entry.
	typedef struct packed {
		logic [KEY_UPPER_W-1:0] key_upper;
		logic [KEY_LOWER_W-1:0] key_lower;
		logic [EXPIRY_W-1:0]    expiry;
	} entry_t;

	// Control word broadcast to every cell of the chain.
	typedef struct packed {
		logic             shift;    // cells at or above pos take their upper neighbour
		logic             load;     // cell at load_pos takes the new entry
		logic             extend;   // cell at pos takes the new expiry
		logic [CNT_W-1:0] pos;
		logic [CNT_W-1:0] load_pos;
	} cell_ctl_t;

endpackage : stwt_pkg
`default_nettype wire

/* src/stwt_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stwt_cell: one slot of the session table chain
// Holds one entry, reports expiry and key match when addressed, and either
// loads a new entry, takes its upper neighbour's entry or refreshes its expiry.
// ----------------------------------------------------------------------------
module stwt_cell #(
	parameter logic [stwt_pkg::CNT_W-1:0] IDX = '0
) (
	input  wire                              clk,
	input  wire stwt_pkg::cell_ctl_t         ctl,
	input  wire stwt_pkg::entry_t            new_entry,
	input  wire [stwt_pkg::NOW_W-1:0]        now,
	input  wire stwt_pkg::entry_t            next_entry,
	output stwt_pkg::entry_t                 entry,
	output logic                             exp_hit,
	output logic                             match_hit
);
	import stwt_pkg::*;

	entry_t entry_q;
	logic   at_pos;

	// Slot update: a new entry wins over the left shift, which wins over a refresh.
	always_ff @(posedge clk) begin
		if (ctl.load && (ctl.load_pos == IDX)) begin
			entry_q <= new_entry;
		end else if (ctl.shift && (IDX >= ctl.pos)) begin
			entry_q <= next_entry;
		end else if (ctl.extend && (ctl.pos == IDX)) begin
			entry_q.expiry <= new_entry.expiry;
		end
	end

	// Flags are only raised by the cell that the sequencer is looking at.
	assign at_pos = (ctl.pos == IDX);
	assign exp_hit = at_pos && (entry_q.expiry < {1'b0, now});
	assign match_hit = at_pos && (entry_q.key_upper == new_entry.key_upper)
		&& (entry_q.key_lower == new_entry.key_lower);
	assign entry = entry_q;

endmodule : stwt_cell
`default_nettype wire

/* src/session_table_with_timeout_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// session_table_with_timeout_unit: aging key table with oldest eviction
// A chain of entry cells kept in insertion order, walked one position a cycle
// by a small sequencer that removes expired entries, refreshes or deletes keys
// and appends new ones, evicting the oldest when the table is full.
// ----------------------------------------------------------------------------
// Order of work: from the accepting edge the walk visits the entries in turn
// (each step either moves on one entry or deletes the one in front of it),
// then ends; a create appends its entry, and then the result is posted. One
// item is in work at a time and the next is taken while the result waits.
// Reset empties the table and sets the timeout to 1800 seconds.
module session_table_with_timeout_unit #(
	parameter int unsigned MAX_SESSIONS = 10
) (
	input  wire                              clk,
	input  wire                              arst_n,
	// configuration: timeout_seconds
	input  wire                              cfg_wen,
	input  wire [stwt_pkg::TIMEOUT_W-1:0]    cfg_wdata,
	// input beats
	input  wire                              s_tvalid,
	output logic                             s_tready,
	input  wire [111:0]                      s_tdata,  // key_upper, key_lower, now_seconds
	input  wire [1:0]                        s_tuser,  // func
	// result beats
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [15:0]                      m_tdata   // ok, evicted_oldest, expired_count,
	                                                   // entries_in_use
);
	import stwt_pkg::*;

	localparam logic [CNT_W-1:0] MAX_W = CNT_W'(MAX_SESSIONS);
	localparam logic [CNT_W-1:0] LAST_W = CNT_W'(MAX_SESSIONS - 1);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_WALK   = 4'b0010,
		ST_WRITE  = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t               state_q;
	logic [TIMEOUT_W-1:0] timeout_q;
	logic [FUNC_W-1:0]    func_q;
	logic [NOW_W-1:0]     now_q;
	entry_t               new_entry_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     ptr_q;
	logic [CNT_W-1:0]     expired_q;
	logic                 ok_q;
	logic                 evicted_q;
	logic                 m_tvalid_q;
	logic [15:0]          m_tdata_q;

	cell_ctl_t            ctl;
	entry_t               cell_entry [MAX_SESSIONS];
	logic [MAX_SESSIONS-1:0] exp_vec;
	logic [MAX_SESSIONS-1:0] match_vec;
	logic                 exp_hit;
	logic                 match_hit;
	logic                 live;
	logic                 full;
	logic                 del_now;
	logic                 ext_now;
	logic                 accept;
	logic                 out_free;

	// Chain of cells; each takes its upper neighbour on a delete.
	for (genvar i = 0; i < MAX_SESSIONS; i++) begin : g_cell
		entry_t next_entry;
		if (i == MAX_SESSIONS - 1) begin : g_tail
			assign next_entry = cell_entry[i];
		end else begin : g_body
			assign next_entry = cell_entry[i+1];
		end
		stwt_cell #(.IDX(CNT_W'(i))) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.new_entry  (new_entry_q),
			.now        (now_q),
			.next_entry (next_entry),
			.entry      (cell_entry[i]),
			.exp_hit    (exp_vec[i]),
			.match_hit  (match_vec[i])
		);
	end

	assign exp_hit = |exp_vec;
	assign match_hit = |match_vec;
	assign live = (ptr_q < count_q);
	assign full = (count_q == MAX_W);
	assign accept = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// Walk decision for the entry under the pointer.
	always_comb begin
		del_now = 1'b0;
		ext_now = 1'b0;
		if ((state_q == ST_WALK) && live) begin
			case (func_q)
				FUNC_CREATE: begin
					del_now = exp_hit;
				end
				FUNC_VALIDATE: begin
					del_now = exp_hit;
					ext_now = !exp_hit && match_hit;
				end
				FUNC_REMOVE: begin
					del_now = match_hit;
				end
				default: begin
					del_now = 1'b0;
				end
			endcase
		end
	end

	// Control word to the chain; the append evicts through position zero when full.
	always_comb begin
		ctl = '0;
		ctl.pos = ptr_q;
		ctl.load_pos = count_q;
		ctl.extend = ext_now;
		ctl.shift = del_now;
		if (state_q == ST_WRITE) begin
			ctl.load = 1'b1;
			ctl.pos = '0;
			ctl.shift = full;
			ctl.load_pos = full ? LAST_W : count_q;
		end
	end

	// Timeout register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_wen) begin
			timeout_q <= cfg_wdata;
		end
	end

	// Item capture, with the new expiry worked out on the way in.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= s_tuser;
			new_entry_q.key_upper <= s_tdata[15:0];
			new_entry_q.key_lower <= s_tdata[79:16];
			new_entry_q.expiry <= {1'b0, s_tdata[111:80]} + {{(EXPIRY_W-TIMEOUT_W){1'b0}}, timeout_q};
			now_q <= s_tdata[111:80];
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			ptr_q <= '0;
			expired_q <= '0;
			ok_q <= 1'b0;
			evicted_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ptr_q <= '0;
						expired_q <= '0;
						ok_q <= 1'b0;
						evicted_q <= 1'b0;
						if ((s_tuser == FUNC_CREATE) || (s_tuser == FUNC_VALIDATE)
							|| (s_tuser == FUNC_REMOVE)) begin
							state_q <= ST_WALK;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_WALK: begin
					if (!live) begin
						state_q <= (func_q == FUNC_CREATE) ? ST_WRITE : ST_FINISH;
					end else if (del_now) begin
						count_q <= count_q - 1'b1;
						if (func_q == FUNC_REMOVE) begin
							ok_q <= 1'b1;
							state_q <= ST_FINISH;
						end else begin
							expired_q <= expired_q + 1'b1;
						end
					end else if (ext_now) begin
						ok_q <= 1'b1;
						state_q <= ST_FINISH;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_WRITE: begin
					ok_q <= 1'b1;
					if (full) begin
						evicted_q <= 1'b1;
					end else begin
						count_q <= count_q + 1'b1;
					end
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result valid: raised when a result is posted, dropped once it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == ST_FINISH) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if ((state_q == ST_FINISH) && out_free) begin
			m_tdata_q <= {count_q, expired_q, evicted_q, ok_q};
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	// The table never holds more entries than it has cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_W)
		else $error("entry count beyond table size");

	// The walk pointer never runs past the live entries.
	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (ptr_q <= count_q))
		else $error("walk pointer past entry count");

	// Once a beat is taken no further beat is taken until the item is done.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("input taken while an item is in work");

	// An eviction is only reported with a full table.
	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_tdata_q[1]) |-> (m_tdata_q[15:9] == MAX_W))
		else $error("eviction reported with table not full");

	// A delete during the walk always takes one entry off the count.
	a_del_count: assert property (@(posedge clk) disable iff (!arst_n)
		del_now |=> (count_q == $past(count_q) - 1'b1))
		else $error("delete did not reduce entry count");

endmodule : session_table_with_timeout_unit
`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for session_table_with_timeout_unit
// Requests are queued by a stimulus process, offered by a clocked driver and
// predicted on acceptance by a behavioural copy of the session table. A
// clocked monitor compares every result beat, field by field, with the oldest
// predicted status. Both sides insert random gaps, and once the result side
// holds off long enough to back up the request side.
// ----------------------------------------------------------------------------
module tb;
	import stwt_pkg::*;

	localparam int unsigned MAX_SESSIONS = 10;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	// Settling wait after the last result, before the next phase starts.
	localparam int unsigned SETTLE_CYCLES = 2 * MAX_SESSIONS + 8;
	localparam int unsigned KEY_POOL_SIZE = 16;

	typedef struct packed {
		logic [FUNC_W-1:0]      func;
		logic [KEY_UPPER_W-1:0] key_upper;
		logic [KEY_LOWER_W-1:0] key_lower;
		logic [NOW_W-1:0]       now;
	} request_t;

	// Same layout as the result tdata: ok in bit 0.
	typedef struct packed {
		logic [CNT_W-1:0] in_use;
		logic [CNT_W-1:0] expired_count;
		logic             evicted_oldest;
		logic             ok;
	} session_status_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 cfg_wen = 1'b0;
	logic [TIMEOUT_W-1:0] cfg_wdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [111:0]         s_tdata = '0;  // key_upper, key_lower, now_seconds
	logic [1:0]           s_tuser = '0;  // func
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [15:0]          m_tdata;       // ok, evicted_oldest, expired_count, entries_in_use

	session_table_with_timeout_unit #(
		.MAX_SESSIONS(MAX_SESSIONS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	request_t             pending_requests[$];
	session_status_t      expected_status[$];
	request_t             on_bus;
	int unsigned          send_gap_pct = 32;
	int unsigned          recv_gap_pct = 70;
	logic                 hold_results = 1'b0;
	int unsigned          results_seen = 0;
	bit                   failed = 1'b0;

	// Behavioural copy of the table and its timeout register.
	entry_t               sessions[MAX_SESSIONS];
	int unsigned          live_count = 0;
	logic [TIMEOUT_W-1:0] timeout_model = TIMEOUT_RESET;

	// Stimulus state: a pool of keys so that lookups hit, and a running clock.
	logic [79:0]          key_pool[KEY_POOL_SIZE];
	logic [NOW_W-1:0]     clock_now;

	// Deletes one entry and closes the gap behind it.
	function automatic void drop_entry(input int unsigned pos);
		for (int unsigned j = pos; j + 1 < live_count; j++) begin
			sessions[j] = sessions[j + 1];
		end
		live_count = live_count - 1;
	endfunction

	// Applies one request to the table copy and returns the status it yields.
	function automatic session_status_t table_apply(input request_t rq);
		session_status_t     st;
		logic [EXPIRY_W-1:0] stamp;
		logic [EXPIRY_W-1:0] renewed;
		int unsigned         w;
		int unsigned         i;
		bit                  found;
		st = '0;
		stamp = {1'b0, rq.now};
		renewed = stamp + {{(EXPIRY_W - TIMEOUT_W){1'b0}}, timeout_model};
		found = 1'b0;
		case (rq.func)
			FUNC_CREATE: begin
				// Sweep every expired entry, keeping the order of the rest.
				w = 0;
				for (i = 0; i < live_count; i++) begin
					if (sessions[i].expiry < stamp) begin
						st.expired_count = st.expired_count + 1'b1;
					end else begin
						sessions[w] = sessions[i];
						w++;
					end
				end
				live_count = w;
				if (live_count >= MAX_SESSIONS) begin
					drop_entry(0);
					st.evicted_oldest = 1'b1;
				end
				sessions[live_count].key_upper = rq.key_upper;
				sessions[live_count].key_lower = rq.key_lower;
				sessions[live_count].expiry = renewed;
				live_count++;
				st.ok = 1'b1;
			end
			FUNC_VALIDATE: begin
				// Expired entries met before the first live match are removed.
				i = 0;
				while (i < live_count && !found) begin
					if (sessions[i].expiry < stamp) begin
						drop_entry(i);
						st.expired_count = st.expired_count + 1'b1;
					end else if (sessions[i].key_upper == rq.key_upper &&
							sessions[i].key_lower == rq.key_lower) begin
						sessions[i].expiry = renewed;
						found = 1'b1;
					end else begin
						i++;
					end
				end
				st.ok = found;
			end
			FUNC_REMOVE: begin
				for (i = 0; i < live_count && !found; i++) begin
					if (sessions[i].key_upper == rq.key_upper &&
							sessions[i].key_lower == rq.key_lower) begin
						drop_entry(i);
						found = 1'b1;
					end
				end
				st.ok = found;
			end
			default: begin
			end
		endcase
		st.in_use = CNT_W'(live_count);
		return st;
	endfunction

	task automatic queue_request(input logic [FUNC_W-1:0] func, input logic [79:0] key,
			input logic [NOW_W-1:0] now);
		request_t rq;
		rq.func = func;
		rq.key_upper = key[79:64];
		rq.key_lower = key[63:0];
		rq.now = now;
		pending_requests.push_back(rq);
	endtask

	// Mostly well-formed traffic on pooled keys with a slowly moving clock;
	// the rest is noise with random keys, codes and times.
	task automatic queue_random_phase(input int unsigned count, input int unsigned step_max);
		int unsigned      done;
		int unsigned      pick;
		logic [FUNC_W-1:0] func;
		logic [79:0]      key;
		logic [NOW_W-1:0] now;
		done = 0;
		clock_now = $urandom;
		while (done < count) begin
			if ($urandom_range(99) < 2) begin
				key_pool[$urandom_range(KEY_POOL_SIZE - 1)] = {$urandom, $urandom, $urandom};
			end
			key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
			if ($urandom_range(99) < 6) begin
				func = FUNC_W'($urandom_range(3));
				if ($urandom_range(1) == 0) begin
					key = {$urandom, $urandom, $urandom};
				end
				now = ($urandom_range(1) == 0) ? NOW_W'($urandom) : clock_now;
			end else begin
				if ($urandom_range(3) == 0) begin
					clock_now = clock_now + NOW_W'($urandom_range(step_max));
				end
				now = clock_now;
				pick = $urandom_range(99);
				if (pick < 40) begin
					func = FUNC_CREATE;
				end else if (pick < 75) begin
					func = FUNC_VALIDATE;
				end else if (pick < 95) begin
					func = FUNC_REMOVE;
				end else begin
					func = FUNC_UNUSED;
				end
				// A key one bit away from a stored one must not match.
				pick = $urandom_range(99);
				if (pick < 5) begin
					key = key ^ (80'd1 << $urandom_range(79));
				end else if (pick < 10) begin
					key = {$urandom, $urandom, $urandom};
				end
			end
			queue_request(func, key, now);
			if (func != FUNC_UNUSED) begin
				done++;
			end
		end
	endtask

	// Waits until every request has been taken and every result has arrived.
	task automatic wait_drained();
		while (pending_requests.size() != 0 || s_tvalid || expected_status.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= value;
		timeout_model = value;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic report_field(input string what, input int unsigned want,
			input int unsigned got);
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
		failed = 1'b1;
	endtask

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Request driver: predicts each accepted beat, then offers the next one.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_status.push_back(table_apply(on_bus));
			end
			if (!s_tvalid || s_tready) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					on_bus = pending_requests.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {on_bus.now, on_bus.key_lower, on_bus.key_upper};
					s_tuser <= on_bus.func;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each result beat against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_status.size() == 0) begin
					$display("%0t: unexpected result beat, actual %h", $time, m_tdata);
					failed = 1'b1;
				end else begin
					if (m_tdata[0] !== expected_status[0].ok) begin
						report_field("ok", expected_status[0].ok, m_tdata[0]);
					end
					if (m_tdata[1] !== expected_status[0].evicted_oldest) begin
						report_field("evicted_oldest", expected_status[0].evicted_oldest,
							m_tdata[1]);
					end
					if (m_tdata[8:2] !== expected_status[0].expired_count) begin
						report_field("expired_count", expected_status[0].expired_count,
							m_tdata[8:2]);
					end
					if (m_tdata[15:9] !== expected_status[0].in_use) begin
						report_field("entries_in_use", expected_status[0].in_use,
							m_tdata[15:9]);
					end
					void'(expected_status.pop_front());
				end
			end
			m_tready <= !hold_results && ($urandom_range(99) >= recv_gap_pct);
		end
	end

	// Long hold-off on the result side while requests keep coming.
	initial begin
		while (results_seen < 60) @(posedge clk);
		hold_results <= 1'b1;
		repeat (400) @(posedge clk);
		hold_results <= 1'b0;
	end

	// Run limit.
	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// Stimulus: directed cases at the reset timeout, then random phases.
	initial begin
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int k = 2; k < KEY_POOL_SIZE; k++) begin
			key_pool[k] = {$urandom, $urandom, $urandom};
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Lookups and the unused code on an empty table.
		queue_request(FUNC_VALIDATE, key_pool[0], '0);
		queue_request(FUNC_REMOVE, key_pool[0], '0);
		queue_request(FUNC_UNUSED, key_pool[1], '1);
		// Fill the table, then overflow it, once with a duplicate key.
		for (int k = 0; k < MAX_SESSIONS + 1; k++) begin
			queue_request(FUNC_CREATE, key_pool[k], '0);
		end
		queue_request(FUNC_CREATE, key_pool[5], '0);
		queue_request(FUNC_VALIDATE, key_pool[5], 32'd100);
		queue_request(FUNC_REMOVE, key_pool[3], 32'd100);
		queue_request(FUNC_UNUSED, key_pool[2], 32'd100);
		// Older entries, this key's among them, have expired by now; nothing matches.
		queue_request(FUNC_VALIDATE, key_pool[7], 32'd1900);
		// Latest time: the expiry needs the extra top bit.
		queue_request(FUNC_CREATE, key_pool[1], '1);
		queue_request(FUNC_VALIDATE, key_pool[1], '1);
		// An expired entry holding the key is removed and does not match.
		queue_request(FUNC_CREATE, key_pool[2], 32'd5000);
		queue_request(FUNC_VALIDATE, key_pool[2], 32'd6801);
		// Remove expires nothing, even at time zero.
		queue_request(FUNC_REMOVE, key_pool[1], '0);
		queue_request(FUNC_REMOVE, key_pool[1], '0);
		wait_drained();

		write_timeout(TIMEOUT_W'(1));
		queue_random_phase(160, 1);
		wait_drained();

		send_gap_pct = 70;
		recv_gap_pct = 32;
		write_timeout('1);
		queue_random_phase(160, 65535 / 2 + 1);
		wait_drained();

		send_gap_pct = 0;
		recv_gap_pct = 0;
		write_timeout(TIMEOUT_W'($urandom_range(2, 300)));
		queue_random_phase(160, timeout_model / 2 + 1);
		wait_drained();

		if (!failed && expected_status.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
